FILE: hdl/dpts_pkg.sv
// ----------------------------------------------------------------------------
// Delayed priority task scheduler package
// Shared field widths, operation and status codes, the table entry type and
// small helper functions for serial time compare and rank mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package dpts_pkg;

   // Field widths
   localparam int OP_W    = 2;
   localparam int DELAY_W = 20;
   localparam int PRIO_W  = 2;
   localparam int TAG_W   = 16;
   localparam int STAT_W  = 3;
   localparam int OCC_W   = 5;
   localparam int TIME_W  = 32;
   localparam int RANK_W  = 2;

   // Default table size
   localparam int TABLE_DEPTH_DEF = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_POST  = 2'd0;
   localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
   localparam logic [OP_W-1:0] OP_SHUT  = 2'd3;

   // Status codes
   localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_DISPATCH = 3'd1;
   localparam logic [STAT_W-1:0] ST_NONE_DUE = 3'd2;
   localparam logic [STAT_W-1:0] ST_REJ_STOP = 3'd3;
   localparam logic [STAT_W-1:0] ST_REJ_FULL = 3'd4;
   localparam logic [STAT_W-1:0] ST_FINISHED = 3'd5;

   // Priority request codes and ranks
   localparam logic [PRIO_W-1:0] PRIO_VISIBLE  = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_BLOCKING = 2'd2;
   localparam logic [RANK_W-1:0] RANK_BLOCKING = 2'd3;
   localparam logic [RANK_W-1:0] RANK_VISIBLE  = 2'd2;
   localparam logic [RANK_W-1:0] RANK_BEST     = 2'd1;

   // One stored task
   typedef struct packed {
      logic [TIME_W-1:0] due;
      logic [RANK_W-1:0] rank;
      logic [TIME_W-1:0] order;
      logic              keep;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // a is before b in wrapping serial arithmetic
   function automatic logic serial_before(input logic [TIME_W-1:0] a,
                                          input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

   // Priority request to dispatch rank; unused code maps to best effort
   function automatic logic [RANK_W-1:0] rank_of(input logic [PRIO_W-1:0] req);
      logic [RANK_W-1:0] rank;
      case (req)
         PRIO_BLOCKING: rank = RANK_BLOCKING;
         PRIO_VISIBLE:  rank = RANK_VISIBLE;
         default:       rank = RANK_BEST;
      endcase
      return rank;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/delayed_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// Delayed priority task scheduler
// Table of pending tasks with due times, ranks and sequence numbers. One
// compare unit walks the table one entry per cycle for fetch and shutdown.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+-----------------------------------
//   req     | in        | req_valid/req_stall | op, delay, priority_req,
//           |           |                     | stop_keep, task_tag
//   rsp     | out       | rsp_valid/rsp_stall | status, dispatched_tag, occupancy
//
// Fetch and shutdown issue one read of the entry memory per cycle, check each
// entry from the registered read, then pass through a retire state and a result
// state. A post searches upward from the first slot for the lowest free one and
// writes it there; tick and rejected posts go straight to the result state. One
// item is in work at a time; req_stall is high while it runs. Reset clears valid
// bits at once; no clearing pass is needed. A stalled result stays in the output
// register; the next item is accepted meanwhile and waits in its result state
// until the register is free.
`default_nettype none

module delayed_priority_task_scheduler
   import dpts_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [DELAY_W-1:0] req_delay,
   input  wire logic [PRIO_W-1:0] req_priority_req,
   input  wire logic              req_stop_keep,
   input  wire logic [TAG_W-1:0]  req_task_tag,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [STAT_W-1:0] rsp_status,
   output      logic [TAG_W-1:0]  rsp_dispatched_tag,
   output      logic [OCC_W-1:0]  rsp_occupancy
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_POST   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_RETIRE = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;

   // Control state
   logic [2:0]             state_ff, state_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [TIME_W-1:0]      order_ff, order_in;
   logic                   stopped_ff, stopped_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   issue_done_ff, issue_done_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic                   cmp_last_ff, cmp_last_in;
   logic                   best_found_ff, best_found_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [OP_W-1:0]        op_ff, op_in;
   entry_type              new_ff, new_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   entry_type              best_ff, best_in;
   logic [STAT_W-1:0]      res_status_ff, res_status_in;
   logic [TAG_W-1:0]       res_tag_ff, res_tag_in;
   logic [STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic [OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;

   // Entry memory
   entry_type              entry_mem [TABLE_DEPTH];
   entry_type              rd_data_ff;
   logic                   mem_we;

   logic                   accept;
   logic [TIME_W:0]        due_sum;
   logic [TIME_W-1:0]      due_new;
   logic                   cand_due;
   logic                   cand_better;
   logic                   out_free;

   assign req_stall          = (state_ff != S_IDLE);
   assign accept             = req_valid && !req_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_dispatched_tag = rsp_tag_ff;
   assign rsp_occupancy      = rsp_occ_ff;
   assign out_free           = !rsp_valid_ff || !rsp_stall;

   // Due time of a new post, saturating
   assign due_sum = {1'b0, time_ff} + (TIME_W + 1)'(req_delay);
   assign due_new = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];

   // Shared compare unit: due check and ordering against the current best
   always_comb begin
      cand_due = !serial_before(time_ff, rd_data_ff.due);
      if (!best_found_ff) begin
         cand_better = 1'b1;
      end else if (rd_data_ff.rank != best_ff.rank) begin
         cand_better = (rd_data_ff.rank > best_ff.rank);
      end else if (rd_data_ff.due != best_ff.due) begin
         cand_better = serial_before(rd_data_ff.due, best_ff.due);
      end else begin
         cand_better = serial_before(rd_data_ff.order, best_ff.order);
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      time_in       = time_ff;
      order_in      = order_ff;
      stopped_in    = stopped_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      cmp_vld_in    = 1'b0;
      cmp_last_in   = 1'b0;
      cmp_idx_in    = idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      op_in         = op_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               new_in.due    = due_new;
               new_in.rank   = rank_of(req_priority_req);
               new_in.order  = order_ff;
               new_in.keep   = req_stop_keep;
               new_in.tag    = req_task_tag;
               idx_in        = '0;
               issue_done_in = 1'b0;
               best_found_in = 1'b0;
               res_status_in = ST_ACCEPTED;
               res_tag_in    = '0;
               case (req_op)
                  OP_POST: begin
                     if (stopped_ff) begin
                        res_status_in = ST_REJ_STOP;
                        state_in      = S_FIN;
                     end else if (count_ff == CNT_FULL) begin
                        res_status_in = ST_REJ_FULL;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_POST;
                     end
                  end
                  OP_FETCH: begin
                     state_in = S_SCAN;
                  end
                  OP_TICK: begin
                     time_in  = time_ff + 1'b1;
                     state_in = S_FIN;
                  end
                  default: begin
                     stopped_in = 1'b1;
                     state_in   = S_SCAN;
                  end
               endcase
            end
         end

         // Look for the lowest free slot, one per cycle
         S_POST: begin
            if (!valid_ff[idx_ff]) begin
               mem_we           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               count_in         = count_ff + 1'b1;
               order_in         = order_ff + 1'b1;
               state_in         = S_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Issue reads, then compare the entry read in the previous cycle
         S_SCAN: begin
            if (!issue_done_ff) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = idx_ff;
               cmp_last_in = (idx_ff == IDX_LAST);
               if (idx_ff == IDX_LAST) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (cmp_vld_ff && valid_ff[cmp_idx_ff]) begin
               if (op_ff == OP_FETCH) begin
                  if (cand_due && cand_better) begin
                     best_found_in = 1'b1;
                     best_idx_in   = cmp_idx_ff;
                     best_in       = rd_data_ff;
                  end
               end else if (!rd_data_ff.keep) begin
                  valid_in[cmp_idx_ff] = 1'b0;
                  count_in             = count_ff - 1'b1;
               end
            end
            if (cmp_vld_ff && cmp_last_ff) begin
               state_in = S_RETIRE;
            end
         end

         // Remove the chosen entry and form the fetch status
         S_RETIRE: begin
            if (op_ff == OP_FETCH) begin
               if (best_found_ff) begin
                  valid_in[best_idx_ff] = 1'b0;
                  count_in              = count_ff - 1'b1;
                  res_status_in         = ST_DISPATCH;
                  res_tag_in            = best_ff.tag;
               end else if (stopped_ff && (count_ff == '0)) begin
                  res_status_in = ST_FINISHED;
               end else begin
                  res_status_in = ST_NONE_DUE;
               end
            end
            state_in = S_FIN;
         end

         // Hand the result to the output register once it is free
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         count_ff      <= '0;
         time_ff       <= '0;
         order_ff      <= '0;
         stopped_ff    <= 1'b0;
         idx_ff        <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         cmp_last_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         time_ff       <= time_in;
         order_ff      <= order_in;
         stopped_ff    <= stopped_in;
         idx_ff        <= idx_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         cmp_last_ff   <= cmp_last_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      new_ff        <= new_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[idx_ff] <= new_ff;
      end
      rd_data_ff <= entry_mem[idx_ff];
   end

   // Checks
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == count_ff)
      else $error("occupancy count differs from valid bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("occupancy count above table depth");

   a_post_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POST |-> count_ff != CNT_FULL)
      else $error("slot search started on a full table");

   a_rej_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_REJ_STOP |-> stopped_ff)
      else $error("post rejected while running");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delayed priority task scheduler testbench
// Drives posts, fetches, ticks and shutdowns through the request channel with
// random sender gaps and result stalls. A table model inside the bench works
// out status, dispatched tag and occupancy for every accepted transfer, and
// each result transfer is compared in order against it.
// ----------------------------------------------------------------------------

module tb;
   import dpts_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1450;

   // Priority request codes the package leaves unnamed
   localparam logic [PRIO_W-1:0] PRIO_BEST  = 2'd0;
   localparam logic [PRIO_W-1:0] PRIO_SPARE = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TAG_W-1:0]  tag;
      logic [OCC_W-1:0]  occ;
   } outcome_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_op = OP_TICK;
   logic [DELAY_W-1:0] req_delay = '0;
   logic [PRIO_W-1:0] req_priority_req = PRIO_BEST;
   logic              req_stop_keep = 1'b0;
   logic [TAG_W-1:0]  req_task_tag = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [TAG_W-1:0]  rsp_dispatched_tag;
   logic [OCC_W-1:0]  rsp_occupancy;

   // Table model state
   logic              tbl_valid [DEPTH];
   logic [TIME_W-1:0] tbl_due   [DEPTH];
   logic [RANK_W-1:0] tbl_rank  [DEPTH];
   logic [TIME_W-1:0] tbl_seq   [DEPTH];
   logic              tbl_keep  [DEPTH];
   logic [TAG_W-1:0]  tbl_tag   [DEPTH];
   logic [TIME_W-1:0] now_ticks = '0;
   logic [TIME_W-1:0] seq_next = '0;
   logic              halted = 1'b0;

   outcome_t awaited_outcomes [$];
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;
   int idle_odds = 0;
   int status_seen [8];
   int op_sent [4];

   delayed_priority_task_scheduler #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_delay          (req_delay),
      .req_priority_req   (req_priority_req),
      .req_stop_keep      (req_stop_keep),
      .req_task_tag       (req_task_tag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_dispatched_tag (rsp_dispatched_tag),
      .rsp_occupancy      (rsp_occupancy)
   );

   always #6 clock = ~clock;

   // a lies before b in wrapping serial order
   function automatic logic precedes(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

   function automatic int occupied();
      int n;
      n = 0;
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i]) n++;
      return n;
   endfunction

   // Apply one accepted request to the table model and return its result
   function automatic outcome_t table_step(input logic [OP_W-1:0]    op,
                                           input logic [DELAY_W-1:0] wait_ticks,
                                           input logic [PRIO_W-1:0]  prio,
                                           input logic               keep,
                                           input logic [TAG_W-1:0]   tag);
      outcome_t res;
      int slot;
      int best;
      logic [TIME_W:0] sum;
      res.status = ST_ACCEPTED;
      res.tag = '0;
      slot = -1;
      best = -1;
      case (op)
         OP_POST: begin
            if (halted) begin
               res.status = ST_REJ_STOP;
            end else begin
               for (int i = 0; i < DEPTH; i++)
                  if (!tbl_valid[i] && slot < 0) slot = i;
               if (slot < 0) begin
                  res.status = ST_REJ_FULL;
               end else begin
                  // due time saturates instead of wrapping
                  sum = {1'b0, now_ticks} + (TIME_W+1)'(wait_ticks);
                  tbl_due[slot] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                  case (prio)
                     PRIO_BLOCKING: tbl_rank[slot] = RANK_BLOCKING;
                     PRIO_VISIBLE:  tbl_rank[slot] = RANK_VISIBLE;
                     default:       tbl_rank[slot] = RANK_BEST;
                  endcase
                  tbl_valid[slot] = 1'b1;
                  tbl_seq[slot] = seq_next;
                  tbl_keep[slot] = keep;
                  tbl_tag[slot] = tag;
                  seq_next = seq_next + 1'b1;
               end
            end
         end
         OP_FETCH: begin
            // among due entries: rank, then due time, then sequence
            for (int i = 0; i < DEPTH; i++) begin
               if (tbl_valid[i] && !precedes(now_ticks, tbl_due[i])) begin
                  if (best < 0) begin
                     best = i;
                  end else if (tbl_rank[i] != tbl_rank[best]) begin
                     if (tbl_rank[i] > tbl_rank[best]) best = i;
                  end else if (tbl_due[i] != tbl_due[best]) begin
                     if (precedes(tbl_due[i], tbl_due[best])) best = i;
                  end else if (precedes(tbl_seq[i], tbl_seq[best])) begin
                     best = i;
                  end
               end
            end
            if (best >= 0) begin
               res.status = ST_DISPATCH;
               res.tag = tbl_tag[best];
               tbl_valid[best] = 1'b0;
            end else if (halted && occupied() == 0) begin
               res.status = ST_FINISHED;
            end else begin
               res.status = ST_NONE_DUE;
            end
         end
         OP_TICK: begin
            now_ticks = now_ticks + 1'b1;
         end
         default: begin
            halted = 1'b1;
            for (int i = 0; i < DEPTH; i++)
               if (!tbl_keep[i]) tbl_valid[i] = 1'b0;
         end
      endcase
      res.occ = OCC_W'(occupied());
      return res;
   endfunction

   // Result check first, then model update for the request taken this edge
   always @(posedge clock) begin : result_check
      outcome_t seen;
      outcome_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_status, rsp_dispatched_tag, rsp_occupancy};
         results_seen++;
         if (awaited_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result status %0d tag %h occupancy %0d",
                        $realtime, seen.status, seen.tag, seen.occ);
         end else begin
            want = awaited_outcomes.pop_front();
            status_seen[want.status]++;
            if (seen.status !== want.status || seen.tag !== want.tag ||
                seen.occ !== want.occ) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch: expected status %0d tag %h occupancy %0d,",
                            " got status %0d tag %h occupancy %0d"}, $realtime,
                           want.status, want.tag, want.occ,
                           seen.status, seen.tag, seen.occ);
            end
         end
      end
      if (!reset && req_valid && !req_stall)
         awaited_outcomes.insert(awaited_outcomes.size(),
                                 table_step(req_op, req_delay, req_priority_req,
                                            req_stop_keep, req_task_tag));
   end

   // Result stalls in random bursts; none while idle_odds is zero
   initial begin
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds / 5) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // One request transfer; entered and left at a falling edge
   task automatic send_item(input logic [OP_W-1:0]    op,
                            input logic [DELAY_W-1:0] wait_ticks,
                            input logic [PRIO_W-1:0]  prio,
                            input logic               keep,
                            input logic [TAG_W-1:0]   tag);
      if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_delay <= wait_ticks;
      req_priority_req <= prio;
      req_stop_keep <= keep;
      req_task_tag <= tag;
      do @(posedge clock); while (req_stall);
      items_sent++;
      op_sent[op]++;
      @(negedge clock);
   endtask

   // Fetch, tick or shutdown with junk in the unused fields
   task automatic send_op(input logic [OP_W-1:0] op);
      logic [31:0] junk;
      junk = $urandom();
      send_item(op, junk[DELAY_W-1:0], junk[21:20], junk[22], junk[31:16]);
   endtask

   task automatic send_random_post();
      int unsigned pick;
      logic [DELAY_W-1:0] wait_ticks;
      logic keep;
      pick = $urandom_range(0, 199);
      keep = 1'($urandom_range(0, 1));
      if (pick == 0) begin
         // far-future task; left droppable so the table can empty after shutdown
         wait_ticks = DELAY_W'($urandom_range(0, 20'hFFFFF));
         keep = 1'b0;
      end else if (pick < 20) begin
         wait_ticks = DELAY_W'($urandom_range(0, 300));
      end else begin
         wait_ticks = DELAY_W'($urandom_range(0, 8));
      end
      send_item(OP_POST, wait_ticks, PRIO_W'($urandom_range(0, 3)), keep,
                TAG_W'($urandom_range(0, 16'hFFFF)));
   endtask

   // Field extremes, rank order, due-time order, sequence order
   task automatic test_ordering();
      send_op(OP_FETCH);
      send_item(OP_POST, '0, PRIO_BEST, 1'b1, 16'h0000);
      send_item(OP_POST, '1, PRIO_BLOCKING, 1'b0, 16'hFFFF);
      send_item(OP_POST, 20'd0, PRIO_VISIBLE, 1'b0, 16'h1111);
      send_item(OP_POST, 20'd2, PRIO_BLOCKING, 1'b1, 16'h2222);
      send_item(OP_POST, 20'd1, PRIO_BLOCKING, 1'b0, 16'h3333);
      send_item(OP_POST, 20'd1, PRIO_BLOCKING, 1'b1, 16'h4444);
      send_item(OP_POST, 20'd0, PRIO_SPARE, 1'b0, 16'h5555);
      send_op(OP_FETCH);
      send_op(OP_TICK);
      send_op(OP_TICK);
      repeat (6) send_op(OP_FETCH);
      send_op(OP_TICK);
   endtask

   // Episodes of post bursts, ticks and fetch runs with mixed noise
   task automatic test_random_traffic();
      int start;
      int burst;
      int unsigned pick;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       idle_odds = 0;
            1:       idle_odds = 10;
            default: idle_odds = 35;
         endcase
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
         repeat (burst) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      send_op(OP_FETCH);
            else if (pick == 1) send_op(OP_TICK);
            else                send_random_post();
         end
         repeat ($urandom_range(0, 6)) send_op(OP_TICK);
         repeat ($urandom_range(1, burst + 3)) begin
            send_op(OP_FETCH);
            if ($urandom_range(0, 3) == 0) send_op(OP_TICK);
         end
      end
   endtask

   // Shutdown pruning, rejected posts, draining kept tasks, finished state
   task automatic test_shutdown();
      int guard;
      logic any_due;
      idle_odds = 0;
      for (int i = 0; i < 6; i++)
         send_item(OP_POST, DELAY_W'(i), PRIO_W'($urandom_range(0, 3)), 1'(i % 2),
                   TAG_W'($urandom_range(0, 16'hFFFF)));
      send_op(OP_SHUT);
      send_item(OP_POST, '0, PRIO_BLOCKING, 1'b1, 16'hA5A5);
      send_item(OP_POST, '0, PRIO_BEST, 1'b0, 16'h5A5A);
      send_op(OP_SHUT);
      // fetch whatever is due, tick otherwise, until the table is empty
      guard = 0;
      while (occupied() != 0 && guard < 3000) begin
         any_due = 1'b0;
         for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && !precedes(now_ticks, tbl_due[i])) any_due = 1'b1;
         send_op(any_due ? OP_FETCH : OP_TICK);
         guard++;
      end
      send_op(OP_FETCH);
      send_op(OP_FETCH);
      repeat (60) begin
         if ($urandom_range(0, 1) == 0) send_random_post();
         else send_op(OP_W'($urandom_range(1, 3)));
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      for (int i = 0; i < 4; i++) op_sent[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_ordering();
      test_random_traffic();
      test_shutdown();

      // drain, then allow one full fetch time for stray results
      req_valid <= 1'b0;
      for (int n = 0; n < 20000 && awaited_outcomes.size() != 0; n++) @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);
      if (awaited_outcomes.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", awaited_outcomes.size());
      end

      $display("%0d transfers in (%0d post, %0d fetch, %0d tick, %0d shutdown), %0d results",
               items_sent, op_sent[OP_POST], op_sent[OP_FETCH], op_sent[OP_TICK],
               op_sent[OP_SHUT], results_seen);
      $display("dispatched %0d, nothing due %0d, full %0d, stopped %0d, finished %0d, bad %0d",
               status_seen[ST_DISPATCH], status_seen[ST_NONE_DUE], status_seen[ST_REJ_FULL],
               status_seen[ST_REJ_STOP], status_seen[ST_FINISHED], mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: delayed_priority_task_scheduler.f
hdl/dpts_pkg.sv
hdl/delayed_priority_task_scheduler.sv
verif/tb.sv
